### rtl/core/srx_pkg.sv
package srx_pkg;

  localparam int MSG_SIZE = 8;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 3;
  localparam int CNT_W    = $clog2(MSG_SIZE + 1);

  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

  typedef enum logic [2:0] {
    ST_HUNT1,
    ST_HUNT2,
    ST_LEN,
    ST_DATA,
    ST_CHK,
    ST_SKIP,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef struct packed {
    logic              shift;
    logic [BYTE_W-1:0] din;
  } chain_ctrl_t;

endpackage

### rtl/core/srx_in_if.sv
interface srx_in_if import srx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/srx_out_if.sv
interface srx_out_if import srx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic [POS_W-1:0]  byte_position;
  logic              last_of_message;
  logic              frame_status;

  modport source (
    output valid, output payload_byte, output byte_position,
    output last_of_message, output frame_status, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_position,
    input last_of_message, input frame_status, output ready
  );
endinterface

### rtl/core/sync_length_xor_frame_receiver_unit.sv
// Frame receiver for a byte stream: it hunts for the sync pair 0xAA 0x55, reads a length of
// one to MSG_SIZE bytes, collects the payload into a chain of byte cells while folding length
// and data into an XOR checksum, and checks the byte that follows. Every byte up to and
// including the checksum is accepted as soon as it is offered. A good frame then has its
// first byte moved to the head of the cell chain, with zeros shifted in behind a short frame,
// and delivers MSG_SIZE requests, one per cycle while the sink takes them, zero past the
// length and the last one marked; a bad checksum gives a single error request. No byte is
// taken while a frame is being moved or delivered, so the sink's hold-off of a pending
// request also holds off the next frame.
module sync_length_xor_frame_receiver_unit import srx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  srx_in_if.sink    rx_i,
  srx_out_if.source tx_o
);

  chain_ctrl_t       chain_ctrl;
  logic [BYTE_W-1:0] head_byte;

  srx_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_i),
    .tx_o    (tx_o),
    .head_i  (head_byte),
    .chain_o (chain_ctrl)
  );

  srx_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (chain_ctrl),
    .head_o (head_byte)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rx_i.ready && tx_o.valid))
    else $error("Input taken while a request is pending.");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.frame_status) |->
      (tx_o.last_of_message && tx_o.byte_position == '0 && tx_o.payload_byte == '0))
    else $error("Malformed error request.");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.ready && !tx_o.last_of_message) |=>
      (tx_o.valid && tx_o.byte_position == POS_W'($past(tx_o.byte_position) + 1'b1)))
    else $error("Message bytes not delivered in order.");

  a_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_o.valid && tx_o.ready && tx_o.last_of_message) |=> (rx_i.ready && !tx_o.valid))
    else $error("Receiver did not resume after the last request.");

endmodule

### rtl/core/srx_cell.sv
module srx_cell import srx_pkg::*; (
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic [BYTE_W-1:0] d_i,
  output logic [BYTE_W-1:0] q_o
);

  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] data_d;

  assign data_d = shift_i ? d_i : data_q;

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

### rtl/core/srx_chain.sv
module srx_chain import srx_pkg::*; (
  input  logic              clk_i,
  input  chain_ctrl_t       ctrl_i,
  output logic [BYTE_W-1:0] head_o
);

  logic [BYTE_W-1:0] link [MSG_SIZE+1];

  assign link[MSG_SIZE] = ctrl_i.din;

  for (genvar i = 0; i < MSG_SIZE; i++) begin : g_cell
    srx_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl_i.shift),
      .d_i     (link[i+1]),
      .q_o     (link[i])
    );
  end

  assign head_o = link[0];

endmodule

### rtl/core/srx_ctrl.sv
module srx_ctrl import srx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  srx_in_if.sink            rx_i,
  srx_out_if.source         tx_o,
  input  logic [BYTE_W-1:0] head_i,
  output chain_ctrl_t       chain_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BYTE_W-1:0]  xor_q, xor_d;
  logic [CNT_W-1:0]   cnt_inc;
  logic               emit_last;

  assign cnt_inc   = cnt_q + 1'b1;
  assign emit_last = (cnt_q == CNT_W'(MSG_SIZE - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT1;
      len_q   <= '0;
      cnt_q   <= '0;
      xor_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
    end
  end

  always_comb begin
    state_d                 = state_q;
    len_d                   = len_q;
    cnt_d                   = cnt_q;
    xor_d                   = xor_q;
    rx_i.ready              = 1'b0;
    tx_o.valid              = 1'b0;
    tx_o.payload_byte       = '0;
    tx_o.byte_position      = '0;
    tx_o.last_of_message    = 1'b0;
    tx_o.frame_status       = 1'b0;
    chain_o.shift           = 1'b0;
    chain_o.din             = '0;
    case (state_q)
      ST_HUNT1: begin
        rx_i.ready = 1'b1;
        if (rx_i.valid) begin
          state_d = (rx_i.rx_byte == SYNC_FIRST) ? ST_HUNT2 : ST_HUNT1;
        end
      end
      ST_HUNT2: begin
        rx_i.ready = 1'b1;
        if (rx_i.valid) begin
          state_d = (rx_i.rx_byte == SYNC_SECOND) ? ST_LEN : ST_HUNT1;
        end
      end
      ST_LEN: begin
        rx_i.ready = 1'b1;
        if (rx_i.valid) begin
          if (rx_i.rx_byte == '0 || rx_i.rx_byte > BYTE_W'(MSG_SIZE)) begin
            state_d = ST_HUNT1;
          end else begin
            len_d   = rx_i.rx_byte[CNT_W-1:0];
            cnt_d   = '0;
            xor_d   = rx_i.rx_byte;
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        rx_i.ready = 1'b1;
        if (rx_i.valid) begin
          chain_o.shift = 1'b1;
          chain_o.din   = rx_i.rx_byte;
          cnt_d         = cnt_inc;
          xor_d         = xor_q ^ rx_i.rx_byte;
          if (cnt_inc >= len_q) begin
            state_d = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        rx_i.ready = 1'b1;
        if (rx_i.valid) begin
          if (rx_i.rx_byte == xor_q) begin
            if (len_q == CNT_W'(MSG_SIZE)) begin
              cnt_d   = '0;
              state_d = ST_EMIT;
            end else begin
              cnt_d   = len_q;
              state_d = ST_SKIP;
            end
          end else begin
            state_d = ST_ERR;
          end
        end
      end
      ST_SKIP: begin
        // Zeros enter behind the frame until its first byte reaches the head cell.
        chain_o.shift = 1'b1;
        cnt_d         = cnt_inc;
        if (cnt_inc == CNT_W'(MSG_SIZE)) begin
          cnt_d   = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        tx_o.valid           = 1'b1;
        tx_o.payload_byte    = head_i;
        tx_o.byte_position   = cnt_q[POS_W-1:0];
        tx_o.last_of_message = emit_last;
        if (tx_o.ready) begin
          chain_o.shift = 1'b1;
          cnt_d         = cnt_inc;
          if (emit_last) begin
            state_d = ST_HUNT1;
          end
        end
      end
      ST_ERR: begin
        tx_o.valid           = 1'b1;
        tx_o.last_of_message = 1'b1;
        tx_o.frame_status    = 1'b1;
        if (tx_o.ready) begin
          state_d = ST_HUNT1;
        end
      end
      default: begin
        state_d = ST_HUNT1;
      end
    endcase
  end

endmodule

### test/sync_length_xor_frame_receiver_unit_tb.sv
module sync_length_xor_frame_receiver_unit_tb;
  import srx_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 4 * MSG_SIZE + 20;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 200;
  localparam int TIMEOUT_CYCLES = 400000;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_val;
    logic [POS_W-1:0]  pos;
    logic              last;
    logic              status;
  } msg_byte_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  srx_in_if  rx_if ();
  srx_out_if tx_if ();

  sync_length_xor_frame_receiver_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .tx_o   (tx_if)
  );

  logic [BYTE_W-1:0] rx_stream_q[$];
  msg_byte_t         msg_expect_q[$];

  state_e            rx_phase = ST_HUNT1;
  logic [BYTE_W-1:0] frame_buf[MSG_SIZE];
  logic [CNT_W-1:0]  len_seen   = '0;
  logic [CNT_W-1:0]  bytes_seen = '0;
  logic [BYTE_W-1:0] xor_acc    = '0;

  int pushed_total  = 0;
  int taken_total   = 0;
  int checked_total = 0;
  int good_frames   = 0;
  int bad_frames    = 0;
  int miss_count    = 0;
  int send_gap      = 0;
  int send_calm     = 0;
  int ready_gap     = 0;
  int ready_calm    = 0;
  int hold_left     = 0;
  int hold_asks     = 0;
  int hold_done     = 0;
  bit in_fired      = 1'b0;
  bit no_idle       = 1'b0;

  msg_byte_t want;
  msg_byte_t got;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic track_frame(input logic [BYTE_W-1:0] b);
    msg_byte_t m;
    case (rx_phase)
      ST_HUNT2: begin
        rx_phase = (b == SYNC_SECOND) ? ST_LEN : ST_HUNT1;
      end
      ST_LEN: begin
        if (b == 0 || b > MSG_SIZE) begin
          rx_phase = ST_HUNT1;
        end else begin
          len_seen   = b[CNT_W-1:0];
          bytes_seen = '0;
          xor_acc    = b;
          rx_phase   = ST_DATA;
        end
      end
      ST_DATA: begin
        if (bytes_seen < MSG_SIZE) frame_buf[bytes_seen[POS_W-1:0]] = b;
        bytes_seen = bytes_seen + 1'b1;
        xor_acc    = xor_acc ^ b;
        if (bytes_seen >= len_seen) rx_phase = ST_CHK;
      end
      ST_CHK: begin
        if (b == xor_acc) begin
          for (int i = 0; i < MSG_SIZE; i++) begin
            m.byte_val = (i < len_seen) ? frame_buf[i] : '0;
            m.pos      = i[POS_W-1:0];
            m.last     = (i == MSG_SIZE - 1);
            m.status   = 1'b0;
            msg_expect_q.push_back(m);
          end
          good_frames++;
        end else begin
          m.byte_val = '0;
          m.pos      = '0;
          m.last     = 1'b1;
          m.status   = 1'b1;
          msg_expect_q.push_back(m);
          bad_frames++;
        end
        rx_phase = ST_HUNT1;
      end
      default: begin
        rx_phase = (b == SYNC_FIRST) ? ST_HUNT2 : ST_HUNT1;
      end
    endcase
  endtask

  task automatic push_rx(input logic [BYTE_W-1:0] b);
    rx_stream_q.push_back(b);
    pushed_total++;
  endtask

  task automatic push_frame(input int len, input bit corrupt);
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] chk;
    push_rx(SYNC_FIRST);
    push_rx(SYNC_SECOND);
    push_rx(len[BYTE_W-1:0]);
    chk = len[BYTE_W-1:0];
    for (int i = 0; i < len; i++) begin
      d = BYTE_W'($urandom);
      push_rx(d);
      chk = chk ^ d;
    end
    if (corrupt) chk = chk ^ BYTE_W'($urandom_range(1, 255));
    push_rx(chk);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (taken_total != pushed_total || msg_expect_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || in_fired) begin
      if (send_gap > 0) begin
        rx_if.valid <= 1'b0;
        send_gap--;
      end else if (rx_stream_q.size() > 0) begin
        rx_if.rx_byte <= rx_stream_q.pop_front();
        rx_if.valid   <= 1'b1;
        send_gap = no_idle ? 0 : draw_gap(send_calm);
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      tx_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      tx_if.ready <= 1'b0;
      hold_left--;
    end else if (hold_done != hold_asks) begin
      hold_done++;
      hold_left = HOLD_CYCLES - 1;
      tx_if.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      tx_if.ready <= 1'b0;
      ready_gap--;
    end else begin
      tx_if.ready <= 1'b1;
      ready_gap = draw_gap(ready_calm);
    end
  end

  always @(posedge clk_i) begin
    in_fired = rst_ni && rx_if.valid && rx_if.ready;
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      got = '{tx_if.payload_byte, tx_if.byte_position, tx_if.last_of_message,
              tx_if.frame_status};
      if (msg_expect_q.size() == 0) begin
        miss_count++;
        if (miss_count <= MAX_REPORTS)
          $display("Unexpected request: byte %02h pos %0d last %0b status %0b",
                   got.byte_val, got.pos, got.last, got.status);
      end else begin
        want = msg_expect_q.pop_front();
        checked_total++;
        if (got.byte_val !== want.byte_val || got.pos !== want.pos ||
            got.last !== want.last || got.status !== want.status) begin
          miss_count++;
          if (miss_count <= MAX_REPORTS)
            $display("Mismatch: expected byte %02h pos %0d last %0b status %0b, got %02h %0d %0b %0b",
                     want.byte_val, want.pos, want.last, want.status,
                     got.byte_val, got.pos, got.last, got.status);
        end
      end
    end
    if (in_fired) begin
      track_frame(rx_if.rx_byte);
      taken_total++;
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("sync_length_xor_frame_receiver_unit regression: fail");
    $finish;
  end

  initial begin
    int r;
    int start_count;
    logic [BYTE_W-1:0] b;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    tx_if.ready   = 1'b0;
    for (int i = 0; i < MSG_SIZE; i++) frame_buf[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_rx(8'h00);
    push_rx(8'hFF);
    push_rx(SYNC_FIRST);
    push_rx(SYNC_FIRST);
    push_rx(SYNC_SECOND);
    push_rx(SYNC_FIRST);
    push_rx(SYNC_SECOND);
    push_rx(8'h00);
    push_rx(SYNC_FIRST);
    push_rx(SYNC_SECOND);
    push_rx(BYTE_W'(MSG_SIZE + 1));
    push_rx(SYNC_FIRST);
    push_rx(SYNC_SECOND);
    push_rx(8'h01);
    push_rx(8'hFF);
    push_rx(8'hFE);
    push_rx(SYNC_FIRST);
    push_rx(SYNC_SECOND);
    push_rx(8'h01);
    push_rx(8'h00);
    push_rx(8'h00);
    wait_drained();

    hold_asks++;
    no_idle = 1'b1;
    push_frame(MSG_SIZE, 1'b0);
    push_frame(MSG_SIZE, 1'b0);
    push_frame(1, 1'b0);
    push_frame(MSG_SIZE, 1'b1);
    wait_drained();
    no_idle = 1'b0;

    start_count = pushed_total;
    while (pushed_total - start_count < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        push_frame($urandom_range(1, MSG_SIZE), 1'b0);
      end else if (r < 80) begin
        push_frame($urandom_range(1, MSG_SIZE), 1'b1);
      end else if (r < 88) begin
        push_rx(SYNC_FIRST);
        push_rx(SYNC_SECOND);
        if ($urandom_range(0, 1)) push_rx(8'h00);
        else push_rx(BYTE_W'($urandom_range(MSG_SIZE + 1, 255)));
      end else if (r < 94) begin
        push_rx(SYNC_FIRST);
        b = BYTE_W'($urandom);
        push_rx(b);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          b = BYTE_W'($urandom);
          push_rx(b);
        end
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (msg_expect_q.size() != 0) begin
      miss_count++;
      $display("%0d expected requests never arrived", msg_expect_q.size());
    end
    $display("Sent %0d received bytes, giving %0d good frames and %0d checksum errors.",
             taken_total, good_frames, bad_frames);
    $display("Compared %0d message bytes, including a %0d-cycle sink hold-off; %0d failures.",
             checked_total, HOLD_CYCLES, miss_count);
    if (miss_count == 0) begin
      $display("sync_length_xor_frame_receiver_unit regression: pass");
    end else begin
      $display("sync_length_xor_frame_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/srx_pkg.sv
rtl/core/srx_in_if.sv
rtl/core/srx_out_if.sv
rtl/core/srx_cell.sv
rtl/core/srx_chain.sv
rtl/core/srx_ctrl.sv
rtl/core/sync_length_xor_frame_receiver_unit.sv
test/sync_length_xor_frame_receiver_unit_tb.sv
